// ===== hdl/beep_pattern_sequencer_macros.svh =====
// Assertion macros used by the checker file of the beep pattern sequencer.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef BEEP_PATTERN_SEQUENCER_MACROS_SVH
`define BEEP_PATTERN_SEQUENCER_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define BPS_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Implication into the following cycle, outside reset.
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Implication into the following cycle, checked during reset as well.
`define BPS_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bps_pkg.sv =====
// Shared types and operation codes of the beep pattern sequencer.
// Depends on nothing; used by the core, the segment store and the top level.
package bps_pkg;

    // Operation codes of an input item.
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_LOAD    = 3'd1;
    localparam logic [2:0] OP_START   = 3'd2;
    localparam logic [2:0] OP_CONT_ON = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;

    // Fixed field widths.
    localparam int OP_W   = 3;
    localparam int SLOT_W = 4;
    localparam int DUR_W  = 16;
    localparam int LEN_W  = 8;
    localparam int SEG_W  = 5;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [DUR_W-1:0]  t_dur;
    typedef logic [LEN_W-1:0]  t_len;

    // Write request from the core to the segment store.
    typedef struct packed {
        logic  we;
        t_slot slot;
        t_dur  data;
    } t_store_wr;

endpackage

// ===== hdl/bps_store.sv =====
// Segment duration store with per-entry valid bits and a registered read port.
// Depends on bps_pkg for the write request type.
module bps_store #(
    parameter int SEGMENT_DEPTH = 16,
    parameter int POS_W         = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bps_pkg::t_store_wr i_wr,
    input  logic [POS_W-1:0]  i_rd_pos,
    output bps_pkg::t_dur     o_limit
);
    import bps_pkg::*;

    localparam int AW = (SEGMENT_DEPTH > 1) ? $clog2(SEGMENT_DEPTH) : 1;

    t_dur                     r_mem [SEGMENT_DEPTH];
    logic [SEGMENT_DEPTH-1:0] r_vld;
    t_dur                     r_rd_data;
    t_dur                     r_fwd_data;
    logic                     r_sel_fwd;
    logic                     r_sel_zero;

    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic          w_rd_in_range;
    logic          w_hit;

    assign w_wr_addr     = AW'(i_wr.slot);
    assign w_rd_addr     = AW'(i_rd_pos);
    assign w_rd_in_range = (32'(i_rd_pos) < SEGMENT_DEPTH);
    assign w_hit         = i_wr.we && w_rd_in_range && (w_wr_addr == w_rd_addr);

    // Storage array; the write request is already limited to slots in range.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[w_wr_addr] <= i_wr.data;
        end
        r_rd_data  <= r_mem[w_rd_addr];
        r_fwd_data <= i_wr.data;
    end

    // Valid bits stand in for clearing the array at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.we) begin
            r_vld[w_wr_addr] <= 1'b1;
        end
    end

    // Read selection: forward a same-cycle write, else zero for empty or out of range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_fwd  <= 1'b0;
            r_sel_zero <= 1'b1;
        end else begin
            r_sel_fwd  <= w_hit;
            r_sel_zero <= !w_rd_in_range || (!w_hit && !r_vld[w_rd_addr]);
        end
    end

    assign o_limit = r_sel_zero ? '0 : (r_sel_fwd ? r_fwd_data : r_rd_data);

endmodule

// ===== hdl/bps_core.sv =====
// Pattern state registers and the per-item update logic.
// Depends on bps_pkg for operation codes and the store write request.
module bps_core #(
    parameter int SEGMENT_DEPTH = 16,
    parameter int POS_W         = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  bps_pkg::t_op       i_operation,
    input  bps_pkg::t_slot     i_segment_slot,
    input  bps_pkg::t_dur      i_segment_duration,
    input  bps_pkg::t_len      i_pattern_length,
    input  bps_pkg::t_dur      i_limit,
    output bps_pkg::t_store_wr o_store_wr,
    output logic [POS_W-1:0]   o_next_pos,
    output logic               o_drive,
    output logic               o_playing,
    output logic [POS_W-1:0]   o_pos
);
    import bps_pkg::*;

    logic [POS_W-1:0] r_total;
    logic [POS_W-1:0] r_pos;
    t_dur             r_elapsed;
    logic             r_playing;
    logic             r_drive;

    logic [POS_W-1:0] n_total;
    logic [POS_W-1:0] n_pos;
    t_dur             n_elapsed;
    logic             n_playing;
    logic             n_drive;

    t_dur             w_elapsed_inc;
    logic [POS_W-1:0] w_pos_inc;

    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign w_pos_inc     = r_pos + 1'b1;

    // Next state and store write for the item in the input register.
    always_comb begin
        n_total    = r_total;
        n_pos      = r_pos;
        n_elapsed  = r_elapsed;
        n_playing  = r_playing;
        n_drive    = r_drive;
        o_store_wr = '{we: 1'b0, slot: i_segment_slot, data: i_segment_duration};
        if (i_advance) begin
            unique case (i_operation)
                OP_TICK: begin
                    n_elapsed = w_elapsed_inc;
                    if (r_playing && (w_elapsed_inc >= i_limit)) begin
                        n_pos     = w_pos_inc;
                        n_elapsed = '0;
                        if (w_pos_inc >= r_total) begin
                            n_playing = 1'b0;
                            n_drive   = 1'b0;
                        end else begin
                            n_drive = !w_pos_inc[0];
                        end
                    end
                end
                OP_LOAD: begin
                    o_store_wr.we = (32'(i_segment_slot) < SEGMENT_DEPTH);
                end
                OP_START: begin
                    n_total   = (32'(i_pattern_length) < SEGMENT_DEPTH) ?
                                POS_W'(i_pattern_length) : POS_W'(SEGMENT_DEPTH);
                    n_pos     = '0;
                    n_elapsed = '0;
                    n_playing = 1'b1;
                    n_drive   = 1'b1;
                end
                OP_CONT_ON: begin
                    n_playing = 1'b0;
                    n_drive   = 1'b1;
                end
                OP_STOP: begin
                    n_playing = 1'b0;
                    n_drive   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // State registers, which also hold the result shown on the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_pos     <= '0;
            r_elapsed <= '0;
            r_playing <= 1'b0;
            r_drive   <= 1'b0;
        end else begin
            r_total   <= n_total;
            r_pos     <= n_pos;
            r_elapsed <= n_elapsed;
            r_playing <= n_playing;
            r_drive   <= n_drive;
        end
    end

    assign o_next_pos = n_pos;
    assign o_drive    = r_drive;
    assign o_playing  = r_playing;
    assign o_pos      = r_pos;

endmodule

// ===== hdl/beep_pattern_sequencer.sv =====
// Top level of the beep pattern sequencer: input register, handshakes, core and store.
// Depends on bps_pkg, bps_core and bps_store.
//
//   channel | direction | handshake              | payload
//   in      | input     | i_in_valid, o_in_stall | i_operation, i_segment_slot,
//           |           |                        | i_segment_duration, i_pattern_length
//   out     | output    | o_out_valid, i_out_stall | o_buzzer_on, o_pattern_active,
//           |           |                        | o_current_segment
//
// One item per cycle sustained while no output stall holds it; a result is offered once its item
// has passed the input register and then the state and result valid registers.
// The store is read ahead at the next segment position, so each tick compares against
// a registered duration.
// Reset clears all control state and the store valid bits.
// An output stall holds the result; the input stalls only when its register is also full.
module beep_pattern_sequencer #(
    parameter int SEGMENT_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bps_pkg::t_op         i_operation,
    input  bps_pkg::t_slot       i_segment_slot,
    input  bps_pkg::t_dur        i_segment_duration,
    input  bps_pkg::t_len        i_pattern_length,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_buzzer_on,
    output logic                 o_pattern_active,
    output logic [bps_pkg::SEG_W-1:0] o_current_segment
);
    import bps_pkg::*;

    localparam int POS_W = $clog2(SEGMENT_DEPTH + 1);

    logic  r_in_valid;
    t_op   r_op;
    t_slot r_slot;
    t_dur  r_dur;
    t_len  r_len;
    logic  r_out_valid;

    logic             w_accept;
    logic             w_advance;
    t_store_wr        w_store_wr;
    t_dur             w_limit;
    logic [POS_W-1:0] w_next_pos;
    logic [POS_W-1:0] w_pos;
    logic [POS_W+SEG_W-1:0] w_pos_ext;

    // The held item moves on when the result slot is free or being taken.
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_operation;
            r_slot <= i_segment_slot;
            r_dur  <= i_segment_duration;
            r_len  <= i_pattern_length;
        end
    end

    // Result valid flag; the result payload is the core state itself.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    bps_core #(
        .SEGMENT_DEPTH (SEGMENT_DEPTH),
        .POS_W         (POS_W)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_advance          (w_advance),
        .i_operation        (r_op),
        .i_segment_slot     (r_slot),
        .i_segment_duration (r_dur),
        .i_pattern_length   (r_len),
        .i_limit            (w_limit),
        .o_store_wr         (w_store_wr),
        .o_next_pos         (w_next_pos),
        .o_drive            (o_buzzer_on),
        .o_playing          (o_pattern_active),
        .o_pos              (w_pos)
    );

    bps_store #(
        .SEGMENT_DEPTH (SEGMENT_DEPTH),
        .POS_W         (POS_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_store_wr),
        .i_rd_pos (w_next_pos),
        .o_limit  (w_limit)
    );

    // The reported position keeps its low five bits.
    assign w_pos_ext         = {{SEG_W{1'b0}}, w_pos};
    assign o_current_segment = w_pos_ext[SEG_W-1:0];
    assign o_out_valid       = r_out_valid;

endmodule

// ===== hdl/bps_checker.sv =====
// Port-level checker for the beep pattern sequencer, bound to the top level.
// Depends on beep_pattern_sequencer_macros.svh and bps_pkg.
`include "beep_pattern_sequencer_macros.svh"

module bps_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic                       o_buzzer_on,
    input logic                       o_pattern_active,
    input logic [bps_pkg::SEG_W-1:0]  o_current_segment
);

    // A stalled result stays offered.
    `BPS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // While a pattern plays, even segments sound and odd segments are silent.
    `BPS_ASSERT_NOW(a_parity, !(o_out_valid && o_pattern_active) || (o_buzzer_on == !o_current_segment[0]), "buzzer level does not follow segment parity")

    // The input stalls only behind a result that is itself stalled.
    `BPS_ASSERT_NOW(a_stall_cause, !o_in_stall || (o_out_valid && i_out_stall), "input stalled without output back-pressure")

    // Reset leaves no result, a silent buzzer and no pattern.
    `BPS_ASSERT_ALWAYS_NEXT(a_reset, !i_rst_n, !o_out_valid && !o_buzzer_on && !o_pattern_active, "state not cleared by reset")

endmodule

bind beep_pattern_sequencer bps_checker u_bps_checker (.*);
